FILE: rtl/assert_macros.svh
// assertion macros used by the top level of the priority queue
// no dependencies; each macro is a clocked concurrent assertion with reset disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// next-cycle implication
`define SFQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

FILE: rtl/sfq_pkg.sv
// shared types, codes and helpers of the stable four-level priority queue
// no dependencies; used by sfq_ctrl, sfq_datapath and the top level
`default_nettype none

package sfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_LEVELS      = 4;

  localparam int KEY_W   = 64;
  localparam int CARR_W  = 8;
  localparam int URG_W   = 3;
  localparam int FUEL_W  = 7;
  localparam int LVL_W   = 2;
  localparam int POS_W   = 5;
  localparam int SERV_W  = 32;

  // request actions
  localparam logic [1:0] ACT_ENQ    = 2'd0;
  localparam logic [1:0] ACT_DEQ    = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CARR_W-1:0] carrier;
    logic              takeoff;
    logic [LVL_W-1:0]  lvl;      // urgency minus one
    logic [FUEL_W-1:0] fuel;
  } entry_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic [CARR_W-1:0] carrier;
    logic              takeoff;
    logic [URG_W-1:0]  urgency;
    logic [FUEL_W-1:0] fuel;
  } req_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch an accepted request
    logic exec;   // run enqueue, dequeue or peek and write the result
    logic scan;   // compare head against the probe and rotate one place
    logic fin;    // write the search result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       count_zero;
    logic       scan_last;
    logic       out_free;
  } sts_t;

  // urgency 0 acts as 1, 5..7 act as 4
  function automatic logic [LVL_W-1:0] clamp_lvl(input logic [URG_W-1:0] urg);
    logic [LVL_W-1:0] res;
    if (urg == URG_W'(0)) begin
      res = LVL_W'(0);
    end else if (urg >= URG_W'(NUM_LEVELS)) begin
      res = LVL_W'(NUM_LEVELS - 1);
    end else begin
      res = LVL_W'(urg - URG_W'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/stable_four_level_priority_queue.sv
// Stable four-level priority queue, up to QUEUE_DEPTH entries sorted by urgency
// (1 most urgent), equal urgency kept in arrival order.
// Input channel in_*: one request per action (enqueue, dequeue, peek, search by key),
// accepted when in_valid is high and in_stall is low. Result channel out_*: exactly
// one result per request, taken when out_valid is high and out_stall is low.
// Enqueue, dequeue and peek: the result is registered from the execute state, and
// the next request is accepted once the block is back in idle. Search rotates the
// entries past the head comparator one per cycle, then registers its result from
// the final state; the next request is accepted once the block is back in idle.
// Insert position comes from per-level counts, so no scan is needed.
// One request can be accepted while an earlier result still waits in the output
// register; the block then holds that request until the register frees, and holds
// in_stall high meanwhile. A stalled result keeps its value.
// Reset (rst_n low, synchronous) empties the queue and clears the served count; no
// clearing pass is needed and the block accepts requests in the first cycle after.
// Depends on sfq_pkg, sfq_ctrl, sfq_datapath and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module stable_four_level_priority_queue #(
  parameter int QUEUE_DEPTH = sfq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_action,
  input  wire logic [sfq_pkg::KEY_W-1:0]     in_flight_key,
  input  wire logic [sfq_pkg::CARR_W-1:0]    in_carrier_code,
  input  wire logic                          in_is_takeoff,
  input  wire logic [sfq_pkg::URG_W-1:0]     in_urgency,
  input  wire logic [sfq_pkg::FUEL_W-1:0]    in_fuel_percent,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [sfq_pkg::KEY_W-1:0]          out_key,
  output logic [sfq_pkg::CARR_W-1:0]         out_carrier,
  output logic                               out_takeoff,
  output logic [sfq_pkg::URG_W-1:0]          out_urgency,
  output logic [sfq_pkg::FUEL_W-1:0]         out_fuel,
  output logic [sfq_pkg::POS_W-1:0]          out_position,
  output logic [sfq_pkg::SERV_W-1:0]         out_served_total,
  output logic [sfq_pkg::POS_W-1:0]          out_occupancy
);

  sfq_pkg::req_t req_w;
  sfq_pkg::cmd_t cmd_w;
  sfq_pkg::sts_t sts_w;

  assign req_w.action  = in_action;
  assign req_w.key     = in_flight_key;
  assign req_w.carrier = in_carrier_code;
  assign req_w.takeoff = in_is_takeoff;
  assign req_w.urgency = in_urgency;
  assign req_w.fuel    = in_fuel_percent;

  sfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts_w),
    .cmd      (cmd_w)
  );

  sfq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_in           (req_w),
    .cmd              (cmd_w),
    .sts              (sts_w),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_key          (out_key),
    .out_carrier      (out_carrier),
    .out_takeoff      (out_takeoff),
    .out_urgency      (out_urgency),
    .out_fuel         (out_fuel),
    .out_position     (out_position),
    .out_served_total (out_served_total),
    .out_occupancy    (out_occupancy)
  );

  // the block is always busy in the cycle after it accepts a request
  `SFQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // an empty report means nothing is held
  `SFQ_ASSERT_IMP(a_empty_occ, clk, rst_n,
    out_valid && (out_status == sfq_pkg::ST_EMPTY), out_occupancy == '0)
  // only a found search carries a position
  `SFQ_ASSERT_IMP(a_pos_only_ok, clk, rst_n,
    out_valid && (out_position != '0), out_status == sfq_pkg::ST_OK)
  // failed requests return no entry
  `SFQ_ASSERT_IMP(a_fail_no_entry, clk, rst_n,
    out_valid && (out_status != sfq_pkg::ST_OK), out_urgency == '0)

endmodule

`default_nettype wire

FILE: rtl/sfq_ctrl.sv
// controller of the priority queue: request sequencing and search scan control
// depends on sfq_pkg for the command and status structs and the action codes
`default_nettype none

module sfq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  sfq_pkg::sts_t      sts,
  output sfq_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.action == sfq_pkg::ACT_SEARCH) begin
          state_nxt = sts.count_zero ? S_FIN : S_SCAN;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sfq_datapath.sv
// datapath of the priority queue: entry cells, level counts, scan and result register
// depends on sfq_pkg for entry, request, command and status types
`default_nettype none

module sfq_datapath #(
  parameter int QUEUE_DEPTH = sfq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  sfq_pkg::req_t                      req_in,
  input  sfq_pkg::cmd_t                      cmd,
  output sfq_pkg::sts_t                      sts,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [sfq_pkg::KEY_W-1:0]          out_key,
  output logic [sfq_pkg::CARR_W-1:0]         out_carrier,
  output logic                               out_takeoff,
  output logic [sfq_pkg::URG_W-1:0]          out_urgency,
  output logic [sfq_pkg::FUEL_W-1:0]         out_fuel,
  output logic [sfq_pkg::POS_W-1:0]          out_position,
  output logic [sfq_pkg::SERV_W-1:0]         out_served_total,
  output logic [sfq_pkg::POS_W-1:0]          out_occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int NL = sfq_pkg::NUM_LEVELS;

  sfq_pkg::req_t   req_r;
  sfq_pkg::entry_t cell_r [QUEUE_DEPTH];
  sfq_pkg::entry_t new_entry;
  sfq_pkg::entry_t hit_r;
  sfq_pkg::entry_t res_entry;

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   cnt_nxt;
  logic [CW-1:0]   lvl_cnt_r [NL];
  logic [CW-1:0]   ins_pos;
  logic [CW-1:0]   hit_pos_r;
  logic [IW-1:0]   idx_r;
  logic            found_r;
  logic [sfq_pkg::SERV_W-1:0] served_r;
  logic [sfq_pkg::SERV_W-1:0] served_nxt;

  logic            full_w;
  logic            empty_w;
  logic            enq_w;
  logic            deq_w;
  logic            out_valid_r;
  logic            res_we;
  logic [1:0]      res_status;
  logic            res_has_entry;
  logic [CW-1:0]   res_pos;

  assign full_w  = (count_r == CW'(QUEUE_DEPTH));
  assign empty_w = (count_r == '0);
  assign enq_w   = cmd.exec && (req_r.action == sfq_pkg::ACT_ENQ) && !full_w;
  assign deq_w   = cmd.exec && (req_r.action == sfq_pkg::ACT_DEQ) && !empty_w;

  assign new_entry.key     = req_r.key;
  assign new_entry.carrier = req_r.carrier;
  assign new_entry.takeoff = req_r.takeoff;
  assign new_entry.lvl     = sfq_pkg::clamp_lvl(req_r.urgency);
  assign new_entry.fuel    = req_r.fuel;

  // sorted insert lands after every entry of equal or higher urgency
  always_comb begin
    ins_pos = '0;
    for (int j = 0; j < NL; j++) begin
      if (sfq_pkg::LVL_W'(j) <= new_entry.lvl) begin
        ins_pos = ins_pos + lvl_cnt_r[j];
      end
    end
  end

  assign cnt_nxt    = enq_w ? count_r + CW'(1) : (deq_w ? count_r - CW'(1) : count_r);
  assign served_nxt = deq_w ? served_r + sfq_pkg::SERV_W'(1) : served_r;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] GIDX = CW'(g);
    sfq_pkg::entry_t up_w;
    sfq_pkg::entry_t dn_w;
    sfq_pkg::entry_t cell_nxt;

    if (g == QUEUE_DEPTH - 1) begin : g_up_last
      assign up_w = cell_r[g];
    end else begin : g_up
      assign up_w = cell_r[g+1];
    end
    if (g == 0) begin : g_dn_first
      assign dn_w = cell_r[g];
    end else begin : g_dn
      assign dn_w = cell_r[g-1];
    end

    always_comb begin
      cell_nxt = cell_r[g];
      if (enq_w) begin
        if (GIDX == ins_pos) begin
          cell_nxt = new_entry;
        end else if (GIDX > ins_pos) begin
          cell_nxt = dn_w;
        end
      end else if (deq_w) begin
        cell_nxt = up_w;
      end else if (cmd.scan) begin
        // rotate: head wraps to the tail so a full pass restores order
        cell_nxt = (GIDX == count_r - CW'(1)) ? cell_r[0] : up_w;
      end
    end

    always_ff @(posedge clk) begin
      cell_r[g] <= cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      served_r <= '0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      for (int j = 0; j < NL; j++) begin
        lvl_cnt_r[j] <= '0;
      end
    end else begin
      count_r  <= cnt_nxt;
      served_r <= served_nxt;
      if (enq_w) begin
        lvl_cnt_r[new_entry.lvl] <= lvl_cnt_r[new_entry.lvl] + CW'(1);
      end else if (deq_w) begin
        lvl_cnt_r[cell_r[0].lvl] <= lvl_cnt_r[cell_r[0].lvl] - CW'(1);
      end
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + IW'(1);
        if (!found_r && (cell_r[0].key == req_r.key)) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_in;
    end
    if (cmd.scan && !found_r && (cell_r[0].key == req_r.key)) begin
      hit_r     <= cell_r[0];
      hit_pos_r <= CW'(idx_r) + CW'(1);
    end
  end

  // result selection
  always_comb begin
    res_status    = sfq_pkg::ST_OK;
    res_has_entry = 1'b0;
    res_entry     = cell_r[0];
    res_pos       = '0;
    if (cmd.fin) begin
      res_entry = hit_r;
      if (found_r) begin
        res_has_entry = 1'b1;
        res_pos       = hit_pos_r;
      end else begin
        res_status = sfq_pkg::ST_MISSING;
      end
    end else begin
      unique case (req_r.action) inside
        sfq_pkg::ACT_ENQ: begin
          res_status = full_w ? sfq_pkg::ST_FULL : sfq_pkg::ST_OK;
        end
        sfq_pkg::ACT_DEQ, sfq_pkg::ACT_PEEK: begin
          if (empty_w) begin
            res_status = sfq_pkg::ST_EMPTY;
          end else begin
            res_has_entry = 1'b1;
          end
        end
        default: begin
          res_status = sfq_pkg::ST_MISSING;
        end
      endcase
    end
  end

  assign res_we = cmd.exec || cmd.fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_we) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      out_status       <= res_status;
      out_key          <= res_has_entry ? res_entry.key : '0;
      out_carrier      <= res_has_entry ? res_entry.carrier : '0;
      out_takeoff      <= res_has_entry ? res_entry.takeoff : 1'b0;
      out_urgency      <= res_has_entry ?
                          sfq_pkg::URG_W'(res_entry.lvl) + sfq_pkg::URG_W'(1) : '0;
      out_fuel         <= res_has_entry ? res_entry.fuel : '0;
      out_position     <= sfq_pkg::POS_W'(res_pos);
      out_served_total <= served_nxt;
      out_occupancy    <= sfq_pkg::POS_W'(cnt_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign sts.action     = req_r.action;
  assign sts.count_zero = empty_w;
  assign sts.scan_last  = ((CW'(idx_r) + CW'(1)) == count_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the stable four-level priority queue
// a queue-fed driver and a result monitor check every response against a shadow copy of the
// queue; depends on sfq_pkg and the stable_four_level_priority_queue rtl
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = sfq_pkg::QUEUE_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 385;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0]                 status;
    logic [sfq_pkg::KEY_W-1:0]  key;
    logic [sfq_pkg::CARR_W-1:0] carrier;
    logic                       takeoff;
    logic [sfq_pkg::URG_W-1:0]  urgency;
    logic [sfq_pkg::FUEL_W-1:0] fuel;
    logic [sfq_pkg::POS_W-1:0]  position;
    logic [sfq_pkg::SERV_W-1:0] served;
    logic [sfq_pkg::POS_W-1:0]  occupancy;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_action = sfq_pkg::ACT_ENQ;
  logic [sfq_pkg::KEY_W-1:0]    in_flight_key = '0;
  logic [sfq_pkg::CARR_W-1:0]   in_carrier_code = '0;
  logic                         in_is_takeoff = 1'b0;
  logic [sfq_pkg::URG_W-1:0]    in_urgency = '0;
  logic [sfq_pkg::FUEL_W-1:0]   in_fuel_percent = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_status;
  logic [sfq_pkg::KEY_W-1:0]    out_key;
  logic [sfq_pkg::CARR_W-1:0]   out_carrier;
  logic                         out_takeoff;
  logic [sfq_pkg::URG_W-1:0]    out_urgency;
  logic [sfq_pkg::FUEL_W-1:0]   out_fuel;
  logic [sfq_pkg::POS_W-1:0]    out_position;
  logic [sfq_pkg::SERV_W-1:0]   out_served_total;
  logic [sfq_pkg::POS_W-1:0]    out_occupancy;

  // requests waiting to be driven and responses the queue still owes
  sfq_pkg::req_t pending_requests[$];
  result_t       awaited_results[$];

  // shadow copy of the queue contents
  sfq_pkg::entry_t shadow_entries[DEPTH];
  int              shadow_fill = 0;
  logic [31:0]     shadow_served = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;

  // occupancy as seen by the stimulus generator
  int          planned_fill = 0;
  logic [63:0] key_pool[16];

  stable_four_level_priority_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_flight_key    (in_flight_key),
    .in_carrier_code  (in_carrier_code),
    .in_is_takeoff    (in_is_takeoff),
    .in_urgency       (in_urgency),
    .in_fuel_percent  (in_fuel_percent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_key          (out_key),
    .out_carrier      (out_carrier),
    .out_takeoff      (out_takeoff),
    .out_urgency      (out_urgency),
    .out_fuel         (out_fuel),
    .out_position     (out_position),
    .out_served_total (out_served_total),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void copy_entry(inout result_t res, input sfq_pkg::entry_t ent);
    res.key     = ent.key;
    res.carrier = ent.carrier;
    res.takeoff = ent.takeoff;
    res.urgency = sfq_pkg::URG_W'(ent.lvl) + sfq_pkg::URG_W'(1);
    res.fuel    = ent.fuel;
  endfunction

  // updates the shadow queue and returns the response owed for one request
  function automatic result_t serve_request(input sfq_pkg::req_t r);
    result_t                   res;
    sfq_pkg::entry_t           ent;
    logic [sfq_pkg::LVL_W-1:0] lvl;
    int                        slot;
    bit                        hit;
    res = '0;
    hit = 1'b0;
    case (r.action) inside
      sfq_pkg::ACT_ENQ: begin
        if (shadow_fill >= DEPTH) begin
          res.status = sfq_pkg::ST_FULL;
        end else begin
          // out-of-range urgency saturates to the nearest level
          case (r.urgency) inside
            3'd0, 3'd1: lvl = 2'd0;
            3'd2:       lvl = 2'd1;
            3'd3:       lvl = 2'd2;
            default:    lvl = 2'd3;
          endcase
          ent.key     = r.key;
          ent.carrier = r.carrier;
          ent.takeoff = r.takeoff;
          ent.lvl     = lvl;
          ent.fuel    = r.fuel;
          slot = 0;
          while (slot < shadow_fill && shadow_entries[slot].lvl <= lvl) slot++;
          for (int i = shadow_fill; i > slot; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[slot] = ent;
          shadow_fill++;
          res.status = sfq_pkg::ST_OK;
        end
      end
      sfq_pkg::ACT_DEQ, sfq_pkg::ACT_PEEK: begin
        if (shadow_fill == 0) begin
          res.status = sfq_pkg::ST_EMPTY;
        end else begin
          copy_entry(res, shadow_entries[0]);
          res.status = sfq_pkg::ST_OK;
          if (r.action == sfq_pkg::ACT_DEQ) begin
            for (int i = 1; i < shadow_fill; i++) shadow_entries[i - 1] = shadow_entries[i];
            shadow_fill--;
            shadow_served++;
          end
        end
      end
      default: begin
        res.status = sfq_pkg::ST_MISSING;
        for (int i = 0; i < shadow_fill; i++) begin
          if (!hit && shadow_entries[i].key == r.key) begin
            hit = 1'b1;
            copy_entry(res, shadow_entries[i]);
            res.status   = sfq_pkg::ST_OK;
            res.position = sfq_pkg::POS_W'(i + 1);
          end
        end
      end
    endcase
    res.served    = shadow_served;
    res.occupancy = sfq_pkg::POS_W'(shadow_fill);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got,
                               inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (fail_count < 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // driver: holds a request until it is taken, then maybe idles
  always @(posedge clk) begin : request_driver
    sfq_pkg::req_t taken;
    sfq_pkg::req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.action  = in_action;
        taken.key     = in_flight_key;
        taken.carrier = in_carrier_code;
        taken.takeoff = in_is_takeoff;
        taken.urgency = in_urgency;
        taken.fuel    = in_fuel_percent;
        awaited_results.push_back(serve_request(taken));
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = pending_requests.pop_front();
          in_valid        <= 1'b1;
          in_action       <= nxt.action;
          in_flight_key   <= nxt.key;
          in_carrier_code <= nxt.carrier;
          in_is_takeoff   <= nxt.takeoff;
          in_urgency      <= nxt.urgency;
          in_fuel_percent <= nxt.fuel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken response against the oldest owed one
  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    bit      bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status    = out_status;
        got.key       = out_key;
        got.carrier   = out_carrier;
        got.takeoff   = out_takeoff;
        got.urgency   = out_urgency;
        got.fuel      = out_fuel;
        got.position  = out_position;
        got.served    = out_served_total;
        got.occupancy = out_occupancy;
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("response with none owed: %p", got);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          bad = 1'b0;
          compare_field("status", 64'(want.status), 64'(got.status), bad);
          compare_field("key", want.key, got.key, bad);
          compare_field("carrier", 64'(want.carrier), 64'(got.carrier), bad);
          compare_field("takeoff", 64'(want.takeoff), 64'(got.takeoff), bad);
          compare_field("urgency", 64'(want.urgency), 64'(got.urgency), bad);
          compare_field("fuel", 64'(want.fuel), 64'(got.fuel), bad);
          compare_field("position", 64'(want.position), 64'(got.position), bad);
          compare_field("served", 64'(want.served), 64'(got.served), bad);
          compare_field("occupancy", 64'(want.occupancy), 64'(got.occupancy), bad);
          if (bad) fail_count++;
        end
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_request(input sfq_pkg::req_t r);
    case (r.action)
      sfq_pkg::ACT_ENQ: if (planned_fill < DEPTH) planned_fill++;
      sfq_pkg::ACT_DEQ: if (planned_fill > 0) planned_fill--;
      default: ;
    endcase
    pending_requests.push_back(r);
  endtask

  task automatic make_request(input logic [1:0] act, input logic [63:0] key,
                              input logic [sfq_pkg::URG_W-1:0] urg,
                              input logic [sfq_pkg::FUEL_W-1:0] fuel,
                              input logic [sfq_pkg::CARR_W-1:0] carrier, input logic takeoff);
    sfq_pkg::req_t r;
    r.action  = act;
    r.key     = key;
    r.carrier = carrier;
    r.takeoff = takeoff;
    r.urgency = urg;
    r.fuel    = fuel;
    push_request(r);
  endtask

  // random traffic that drifts between filling and draining the queue
  task automatic queue_random(input int count);
    sfq_pkg::req_t r;
    int            roll;
    bit            filling;
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) filling = !filling;
      r.key     = {$urandom, $urandom};
      r.carrier = sfq_pkg::CARR_W'($urandom);
      r.takeoff = 1'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        r.urgency = sfq_pkg::URG_W'($urandom_range(1, 4));
      end else begin
        r.urgency = sfq_pkg::URG_W'($urandom_range(0, 3));
        if (r.urgency != 0) r.urgency = r.urgency + sfq_pkg::URG_W'(4);
      end
      r.fuel = ($urandom_range(0, 9) == 0) ? sfq_pkg::FUEL_W'($urandom_range(101, 127))
                                           : sfq_pkg::FUEL_W'($urandom_range(0, 100));
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 55 : 20)) r.action = sfq_pkg::ACT_ENQ;
      else if (roll < 75)             r.action = sfq_pkg::ACT_DEQ;
      else if (roll < 85)             r.action = sfq_pkg::ACT_PEEK;
      else                            r.action = sfq_pkg::ACT_SEARCH;
      if (r.action == sfq_pkg::ACT_ENQ) begin
        if ($urandom_range(0, 3) == 0) r.key = key_pool[$urandom_range(0, 15)];
        else key_pool[$urandom_range(0, 15)] = r.key;
      end else if (r.action == sfq_pkg::ACT_SEARCH && $urandom_range(0, 3) != 0) begin
        r.key = key_pool[$urandom_range(0, 15)];
      end
      if ($urandom_range(0, 32) == 0) r.key = $urandom_range(0, 1) ? '1 : '0;
      push_request(r);
    end
  endtask

  initial begin : stimulus
    int          urg_seq[16];
    int          idle_set[4];
    int          stall_set[4];
    logic [63:0] k;
    logic [63:0] dup_key;
    urg_seq   = '{4, 3, 2, 1, 0, 5, 6, 7, 2, 2, 3, 1, 4, 7, 1, 3};
    idle_set  = '{0, 79, 0, 24};
    stall_set = '{0, 0, 79, 24};
    dup_key   = '0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};

    // empty queue corner cases
    make_request(sfq_pkg::ACT_PEEK, '0, 3'd1, '0, '0, 1'b0);
    make_request(sfq_pkg::ACT_DEQ, '1, 3'd7, '1, '1, 1'b1);
    make_request(sfq_pkg::ACT_SEARCH, '0, 3'd1, '0, '0, 1'b0);
    // fill to capacity with mixed and out-of-range levels, one duplicated key
    for (int i = 0; i < 16; i++) begin
      if (i == 0)      k = '1;
      else if (i == 1) k = '0;
      else if (i == 9) k = dup_key;
      else             k = {$urandom, $urandom};
      if (i == 8) dup_key = k;
      make_request(sfq_pkg::ACT_ENQ, k, sfq_pkg::URG_W'(urg_seq[i]),
                   (i == 0) ? sfq_pkg::FUEL_W'(0) : (i == 1) ? sfq_pkg::FUEL_W'(100) :
                   (i == 2) ? sfq_pkg::FUEL_W'(127) :
                   sfq_pkg::FUEL_W'($urandom_range(0, 100)),
                   (i % 2 == 0) ? sfq_pkg::CARR_W'(255) : sfq_pkg::CARR_W'(i), 1'(i));
    end
    make_request(sfq_pkg::ACT_ENQ, 64'h5555_aaaa_5555_aaaa, 3'd1, 7'd50, 8'd7, 1'b1);
    make_request(sfq_pkg::ACT_SEARCH, dup_key, 3'd0, '0, '0, 1'b0);
    make_request(sfq_pkg::ACT_SEARCH, 64'h0123_4567_89ab_cdef, 3'd0, '0, '0, 1'b0);
    make_request(sfq_pkg::ACT_PEEK, '0, 3'd0, '0, '0, 1'b0);
    make_request(sfq_pkg::ACT_DEQ, '0, 3'd0, '0, '0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // let all directed requests and their responses finish before random traffic starts
    while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      queue_random(RANDOM_PER_PHASE);
      while (pending_requests.size() != 0) @(posedge clk);
    end

    while (in_valid || awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
